FILE: sv/mdc_pkg.sv
// Package for the mission download client.
// Holds the transfer payload types, the phase enum and the message codes.
// No dependencies.
package mdc_pkg;

  localparam int unsigned CfgDataWidth = 16;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT_COUNT,
    PH_REQUEST_ITEM,
    PH_WAIT_ITEM,
    PH_QUIT
  } phase_t;

  localparam logic [1:0] KIND_TICK      = 2'd0;
  localparam logic [1:0] KIND_HEARTBEAT = 2'd1;
  localparam logic [1:0] KIND_COUNT     = 2'd2;
  localparam logic [1:0] KIND_ITEM      = 2'd3;

  localparam logic [1:0] SEND_NONE = 2'd0;
  localparam logic [1:0] SEND_LIST = 2'd1;
  localparam logic [1:0] SEND_ITEM = 2'd2;
  localparam logic [1:0] SEND_ACK  = 2'd3;

  localparam logic [1:0] OUT_RUNNING    = 2'd0;
  localparam logic [1:0] OUT_DONE       = 2'd1;
  localparam logic [1:0] OUT_NO_MISSION = 2'd2;
  localparam logic [1:0] OUT_EXHAUSTED  = 2'd3;

  localparam logic CFG_RETRY_LIMIT  = 1'b0;
  localparam logic CFG_WAIT_TIME_MS = 1'b1;

  localparam logic [3:0]  RETRY_LIMIT_RESET  = 4'd4;
  localparam logic [15:0] WAIT_TIME_MS_RESET = 16'd4000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now;
    logic [15:0] value;
  } ev_item_t;

  typedef struct packed {
    logic [1:0]  send_kind;
    logic [15:0] send_seq;
    logic        item_accepted;
    logic [1:0]  outcome;
  } rsp_item_t;

  typedef struct packed {
    logic [3:0]  retry_limit;
    logic [15:0] wait_time_ms;
  } cfg_t;

endpackage

FILE: sv/mdc_cfg_regs.sv
// Configuration registers of the mission download client.
// Depends on mdc_pkg for the register indexes and the cfg_t bundle.
module mdc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [mdc_pkg::CfgDataWidth-1:0]  cfg_data,
  output mdc_pkg::cfg_t                     cfg
);
  import mdc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.retry_limit  <= RETRY_LIMIT_RESET;
      cfg.wait_time_ms <= WAIT_TIME_MS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RETRY_LIMIT:  cfg.retry_limit  <= cfg_data[3:0];
        CFG_WAIT_TIME_MS: cfg.wait_time_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/mdc_engine.sv
// Protocol state and per-event update of the mission download client.
// Depends on mdc_pkg for the phase enum, the codes and the payload types.
module mdc_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  mdc_pkg::ev_item_t  item,
  input  mdc_pkg::cfg_t      cfg,
  output mdc_pkg::rsp_item_t result
);
  import mdc_pkg::*;

  phase_t      phase, phase_next;
  logic        heartbeat_seen, heartbeat_seen_next;
  logic [15:0] total_items, total_items_next;
  logic [15:0] next_seq, next_seq_next;
  logic [3:0]  tries, tries_next;
  logic [31:0] deadline, deadline_next;
  logic [1:0]  final_outcome, final_outcome_next;

  logic [15:0] seq_inc;
  logic [15:0] seq_dec;
  logic        can_try;
  logic        timed_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      heartbeat_seen <= 1'b0;
      total_items    <= '0;
      next_seq       <= '0;
      tries          <= '0;
      deadline       <= '0;
      final_outcome  <= OUT_RUNNING;
    end else if (fire) begin
      phase          <= phase_next;
      heartbeat_seen <= heartbeat_seen_next;
      total_items    <= total_items_next;
      next_seq       <= next_seq_next;
      tries          <= tries_next;
      deadline       <= deadline_next;
      final_outcome  <= final_outcome_next;
    end
  end

  assign seq_inc   = next_seq + 16'd1;
  assign seq_dec   = next_seq - 16'd1;
  assign can_try   = tries < cfg.retry_limit;
  assign timed_out = item.now > deadline;

  always_comb begin
    phase_next          = phase;
    heartbeat_seen_next = heartbeat_seen;
    total_items_next    = total_items;
    next_seq_next       = next_seq;
    tries_next          = tries;
    deadline_next       = deadline;
    final_outcome_next  = final_outcome;
    result.send_kind     = SEND_NONE;
    result.send_seq      = '0;
    result.item_accepted = 1'b0;

    case (item.kind)
      KIND_TICK: begin
        case (phase)
          PH_IDLE, PH_REQUEST_ITEM: begin
            if (phase == PH_REQUEST_ITEM || heartbeat_seen) begin
              if (can_try) begin
                tries_next    = tries + 4'd1;
                deadline_next = item.now + {16'd0, cfg.wait_time_ms};
                if (phase == PH_IDLE) begin
                  phase_next       = PH_WAIT_COUNT;
                  result.send_kind = SEND_LIST;
                end else begin
                  phase_next       = PH_WAIT_ITEM;
                  result.send_kind = SEND_ITEM;
                  result.send_seq  = next_seq;
                end
              end else begin
                phase_next         = PH_QUIT;
                final_outcome_next = OUT_EXHAUSTED;
              end
            end
          end
          PH_WAIT_COUNT: begin
            if (timed_out) begin
              phase_next = PH_IDLE;
            end
          end
          PH_WAIT_ITEM: begin
            if (timed_out) begin
              phase_next = PH_REQUEST_ITEM;
            end
          end
          default: ;
        endcase
      end
      KIND_HEARTBEAT: begin
        heartbeat_seen_next = 1'b1;
      end
      KIND_COUNT: begin
        if (phase == PH_WAIT_COUNT) begin
          total_items_next = item.value;
          if (item.value == 16'd0) begin
            phase_next         = PH_QUIT;
            final_outcome_next = OUT_NO_MISSION;
          end else begin
            next_seq_next = '0;
            tries_next    = '0;
            phase_next    = PH_REQUEST_ITEM;
          end
        end
      end
      KIND_ITEM: begin
        if (phase == PH_WAIT_ITEM) begin
          if (item.value == next_seq) begin
            result.item_accepted = 1'b1;
            next_seq_next        = seq_inc;
            tries_next           = '0;
            if (seq_inc == total_items) begin
              result.send_kind   = SEND_ACK;
              phase_next         = PH_QUIT;
              final_outcome_next = OUT_DONE;
            end else begin
              phase_next = PH_REQUEST_ITEM;
            end
          end else if (next_seq != 16'd0 && item.value == seq_dec) begin
            phase_next = PH_REQUEST_ITEM;
          end
        end
      end
      default: ;
    endcase

    result.outcome = final_outcome_next;
  end

  a_outcome_sticky: assert property (@(posedge clk) disable iff (rst)
    (final_outcome != OUT_RUNNING) |=> $stable(final_outcome))
    else $error("final outcome changed after the download ended");

  a_outcome_in_quit: assert property (@(posedge clk) disable iff (rst)
    (final_outcome != OUT_RUNNING) |-> (phase == PH_QUIT))
    else $error("final outcome set outside the quit phase");

  a_list_waits_count: assert property (@(posedge clk) disable iff (rst)
    (fire && result.send_kind == SEND_LIST) |=> (phase == PH_WAIT_COUNT))
    else $error("list request sent without waiting for the count");

  a_accept_from_wait: assert property (@(posedge clk) disable iff (rst)
    (fire && result.item_accepted) |-> (phase == PH_WAIT_ITEM && item.kind == KIND_ITEM))
    else $error("item accepted outside the item wait");

endmodule

FILE: sv/mission_download_client.sv
// Mission download client: client side of a mission list download with
// retries and reply timeouts, one event in and one reply out per transfer.
//
// Usage:
//   Events (tick, heartbeat, count message, item message) enter on the ev
//   channel; each accepted event produces exactly one reply on the rsp
//   channel, carrying the message to send, the requested sequence number,
//   the store flag for a received item and the running outcome.
//   Configuration registers (retry limit, wait time) are written through
//   cfg_we, cfg_index and cfg_data; the user must write them only while no
//   event is in flight, as the block itself does not enforce it. An event
//   goes into the event register; the protocol update works on the event
//   register and loads the reply register, from which the reply transfers.
//   Throughput is one event per cycle while rsp_ready stays high; the
//   event register and the reply register form a two-entry pipeline, so a
//   new event is taken while a finished reply still waits to be taken.
//   When the receiver holds rsp_ready low, the reply stays put, the event
//   register fills, and ev_ready drops until the reply transfers.
//   Synchronous reset empties both registers, returns the protocol to idle
//   with no heartbeat seen, and restores retry limit 4 and wait time 4000 ms.
module mission_download_client (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              ev_valid,
  output logic                              ev_ready,
  input  mdc_pkg::ev_item_t                 ev_data,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output mdc_pkg::rsp_item_t                rsp_data,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [mdc_pkg::CfgDataWidth-1:0]  cfg_data
);
  import mdc_pkg::*;

  cfg_t      cfg;
  logic      hold_valid;
  ev_item_t  hold;
  logic      advance;
  rsp_item_t result;

  assign advance  = hold_valid && (!rsp_valid || rsp_ready);
  assign ev_ready = !hold_valid || advance;

  mdc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mdc_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (hold),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (ev_ready) begin
      hold_valid <= ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_valid && ev_ready) begin
      hold <= ev_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_data <= result;
    end
  end

endmodule
